### rtl/core/energy_pulse_accumulator_unit_assert.svh
// Assertion macros for the energy pulse accumulator checker.
// No dependencies; included by the checker file.
`ifndef ENERGY_PULSE_ACCUMULATOR_UNIT_ASSERT_SVH
`define ENERGY_PULSE_ACCUMULATOR_UNIT_ASSERT_SVH

// Clocked assertion, off while reset is high.
`define EPA_ASSERT(lbl, clk, rst, prop) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("energy_pulse_accumulator_unit: assertion failed");

// Clocked assertion that also holds across reset.
`define EPA_ASSERT_NR(lbl, clk, prop) \
  lbl: assert property (@(posedge clk) prop) \
    else $error("energy_pulse_accumulator_unit: reset assertion failed");

`endif

### rtl/core/epa_pkg.sv
// Shared types and constants for the energy pulse accumulator.
// No dependencies.
package epa_pkg;

  localparam int EPA_RESIDUE_WIDTH = 48;
  localparam int EPA_UNIT_WIDTH    = 32;
  localparam int MC_WIDTH          = 47;
  localparam int ON_WIDTH          = 24;
  localparam int TIMER_WIDTH       = 25;
  localparam int TOTAL_WIDTH       = 64;

  typedef logic [0:0] cfg_index_t;
  localparam cfg_index_t REG_PULSE_ENERGY = 1'b0;
  localparam cfg_index_t REG_LIT_TICKS    = 1'b1;

  typedef logic [1:0] quadrant_t;
  localparam quadrant_t QUAD_I   = 2'd0;
  localparam quadrant_t QUAD_II  = 2'd1;
  localparam quadrant_t QUAD_III = 2'd2;
  localparam quadrant_t QUAD_IV  = 2'd3;

  // Control into one residue accumulator.
  typedef struct packed {
    logic step;  // a tick is processed this cycle (not held)
    logic sel;   // this residue is the one the tick feeds
  } accum_ctrl_t;

  // Control into one indicator timer.
  typedef struct packed {
    logic step;   // a tick is processed this cycle (not held)
    logic pulse;  // a quantum completed for this indicator
  } led_ctrl_t;

endpackage

### rtl/core/epa_accum_cell.sv
// One energy residue with its saturating add, quantum compare and pulse total.
// Depends on epa_pkg.
module epa_accum_cell #(
  parameter int RESIDUE_WIDTH = epa_pkg::EPA_RESIDUE_WIDTH,
  parameter int UNIT_WIDTH    = epa_pkg::EPA_UNIT_WIDTH
) (
  input  logic                          clk,
  input  logic                          rst,
  input  epa_pkg::accum_ctrl_t          ctrl,
  input  logic [UNIT_WIDTH-1:0]         mag,
  input  logic [epa_pkg::MC_WIDTH-1:0]  pulse_energy,
  output logic                          pulse
);
  import epa_pkg::*;

  localparam int SUM_W = ((RESIDUE_WIDTH > UNIT_WIDTH) ? RESIDUE_WIDTH : UNIT_WIDTH) + 1;
  localparam int CMP_W = (RESIDUE_WIDTH > MC_WIDTH) ? RESIDUE_WIDTH : MC_WIDTH;

  logic [RESIDUE_WIDTH-1:0] residue;
  logic [RESIDUE_WIDTH-1:0] residue_next;
  logic [TOTAL_WIDTH-1:0]   total;
  logic [SUM_W-1:0]         sum;
  logic [RESIDUE_WIDTH-1:0] sat;
  logic [CMP_W-1:0]         diff;
  logic                     reached;

  always_comb begin
    sum = SUM_W'(residue) + SUM_W'(mag);
    if (sum[SUM_W-1:RESIDUE_WIDTH] != '0) begin
      sat = '1;
    end else begin
      sat = sum[RESIDUE_WIDTH-1:0];
    end
    reached = CMP_W'(sat) >= CMP_W'(pulse_energy);
    diff    = CMP_W'(sat) - CMP_W'(pulse_energy);
    residue_next = reached ? diff[RESIDUE_WIDTH-1:0] : sat;
    pulse = ctrl.step && ctrl.sel && reached;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      residue <= '0;
      total   <= '0;
    end else if (ctrl.step && ctrl.sel) begin
      residue <= residue_next;
      if (reached) begin
        total <= total + TOTAL_WIDTH'(1);
      end
    end
  end

endmodule

### rtl/core/epa_led_timer.sv
// Indicator on-time timer: ages a lit indicator, relights it on a pulse.
// Depends on epa_pkg.
module epa_led_timer (
  input  logic                          clk,
  input  logic                          rst,
  input  epa_pkg::led_ctrl_t            ctrl,
  input  logic [epa_pkg::ON_WIDTH-1:0]  on_count,
  output logic                          lit_next
);
  import epa_pkg::*;

  logic                   lit;
  logic [TIMER_WIDTH-1:0] timer;
  logic [TIMER_WIDTH-1:0] timer_next;
  logic [TIMER_WIDTH-1:0] aged;

  always_comb begin
    aged       = timer + TIMER_WIDTH'(1);
    lit_next   = lit;
    timer_next = timer;
    if (ctrl.step) begin
      if (lit) begin
        timer_next = aged;
        if (aged > TIMER_WIDTH'(on_count)) begin
          lit_next = 1'b0;
        end
      end
      if (ctrl.pulse) begin
        timer_next = '0;
        lit_next   = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      lit   <= 1'b0;
      timer <= '0;
    end else begin
      lit   <= lit_next;
      timer <= timer_next;
    end
  end

endmodule

### rtl/core/energy_pulse_accumulator_unit.sv
// Top level of the four-quadrant energy pulse accumulator.
// Depends on epa_pkg, epa_accum_cell and epa_led_timer.
//
// Usage:
//   sample channel (sample_valid / sample_stall) carries one tick of signed
//   active and reactive energy, apparent energy and the hold flag. result
//   channel (result_valid / result_stall) returns one transaction per tick:
//   the three indicator levels, three quantum pulses and the quadrant.
//   cfg_write / cfg_index / cfg_data write the pulse energy (index 0) or the
//   indicator on-count (index 1); write only while no transaction is in flight.
// Path: a sample taken into the input register goes through the single-pass
//   update into the result register.
// Throughput: one transaction per cycle while the result side is not stalled.
//   The path that sets it is the 48-bit saturating add, compare and subtract
//   in each residue cell, run once per tick between input and result registers.
// Reset: residues, pulse totals and indicator timers clear and the timers go
//   dark, not the LED outputs; pulse energy is 1, on-count 0; both channels empty.
// Stall: a stalled result holds. The input register then holds its tick and
//   sample_stall rises; nothing is lost and state advances only when a tick
//   moves into the result register.
module energy_pulse_accumulator_unit #(
  parameter int RESIDUE_WIDTH = epa_pkg::EPA_RESIDUE_WIDTH,
  parameter int UNIT_WIDTH    = epa_pkg::EPA_UNIT_WIDTH
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_write,
  input  epa_pkg::cfg_index_t           cfg_index,
  input  logic [epa_pkg::MC_WIDTH-1:0]  cfg_data,
  input  logic                          sample_valid,
  output logic                          sample_stall,
  input  logic signed [UNIT_WIDTH-1:0]  active_unit,
  input  logic signed [UNIT_WIDTH-1:0]  reactive_unit,
  input  logic [UNIT_WIDTH-2:0]         apparent_unit,
  input  logic                          hold,
  output logic                          result_valid,
  input  logic                          result_stall,
  output logic                          active_led,
  output logic                          apparent_led,
  output logic                          reactive_led,
  output logic                          active_pulse,
  output logic                          apparent_pulse,
  output logic                          reactive_pulse,
  output epa_pkg::quadrant_t            quadrant
);
  import epa_pkg::*;

  // Residue slots.
  localparam int R_ACT_IMP = 0;
  localparam int R_ACT_EXP = 1;
  localparam int R_APP_IMP = 2;
  localparam int R_APP_EXP = 3;
  localparam int R_IND_IMP = 4;
  localparam int R_IND_EXP = 5;
  localparam int R_CAP_IMP = 6;
  localparam int R_CAP_EXP = 7;

  // Configuration registers.
  logic [MC_WIDTH-1:0] pulse_energy;
  logic [ON_WIDTH-1:0] lit_ticks;

  always_ff @(posedge clk) begin
    if (rst) begin
      pulse_energy <= MC_WIDTH'(1);
      lit_ticks    <= '0;
    end else if (cfg_write) begin
      case (cfg_index)
        REG_PULSE_ENERGY: pulse_energy <= cfg_data;
        REG_LIT_TICKS:    lit_ticks    <= cfg_data[ON_WIDTH-1:0];
        default:          ;
      endcase
    end
  end

  // Input register.
  logic                  in_full;
  logic [UNIT_WIDTH-1:0] in_active;
  logic [UNIT_WIDTH-1:0] in_reactive;
  logic [UNIT_WIDTH-2:0] in_apparent;
  logic                  in_hold;
  logic                  out_free;
  logic                  fire;
  logic                  step;

  assign out_free     = !result_valid || !result_stall;
  assign fire         = in_full && out_free;
  assign step         = fire && !in_hold;
  assign sample_stall = in_full && !out_free;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_full <= 1'b0;
    end else if (sample_valid && !sample_stall) begin
      in_full <= 1'b1;
    end else if (fire) begin
      in_full <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (sample_valid && !sample_stall) begin
      in_active   <= active_unit;
      in_reactive <= reactive_unit;
      in_apparent <= apparent_unit;
      in_hold     <= hold;
    end
  end

  // Sign and magnitude; the most negative code maps to 2^(W-1), which fits.
  logic                  act_neg;
  logic                  react_neg;
  logic [UNIT_WIDTH-1:0] act_mag;
  logic [UNIT_WIDTH-1:0] react_mag;
  logic [UNIT_WIDTH-1:0] app_mag;
  quadrant_t             quad;

  always_comb begin
    act_neg   = in_active[UNIT_WIDTH-1];
    react_neg = in_reactive[UNIT_WIDTH-1];
    act_mag   = act_neg ? (~in_active + UNIT_WIDTH'(1)) : in_active;
    react_mag = react_neg ? (~in_reactive + UNIT_WIDTH'(1)) : in_reactive;
    app_mag   = UNIT_WIDTH'(in_apparent);
    if (!act_neg) begin
      quad = react_neg ? QUAD_IV : QUAD_I;
    end else begin
      quad = react_neg ? QUAD_III : QUAD_II;
    end
  end

  // Residue cells: one per register, only the selected ones advance.
  accum_ctrl_t           cell_ctrl [8];
  logic [UNIT_WIDTH-1:0] cell_mag  [8];
  logic [7:0]            cell_pulse;

  always_comb begin
    for (int i = 0; i < 8; i++) begin
      cell_ctrl[i].step = step;
    end
    cell_ctrl[R_ACT_IMP].sel = !act_neg;
    cell_ctrl[R_ACT_EXP].sel = act_neg;
    cell_ctrl[R_APP_IMP].sel = !act_neg;
    cell_ctrl[R_APP_EXP].sel = act_neg;
    cell_ctrl[R_IND_IMP].sel = (quad == QUAD_I);
    cell_ctrl[R_CAP_EXP].sel = (quad == QUAD_IV);
    cell_ctrl[R_CAP_IMP].sel = (quad == QUAD_II);
    cell_ctrl[R_IND_EXP].sel = (quad == QUAD_III);
    cell_mag[R_ACT_IMP] = act_mag;
    cell_mag[R_ACT_EXP] = act_mag;
    cell_mag[R_APP_IMP] = app_mag;
    cell_mag[R_APP_EXP] = app_mag;
    cell_mag[R_IND_IMP] = react_mag;
    cell_mag[R_IND_EXP] = react_mag;
    cell_mag[R_CAP_IMP] = react_mag;
    cell_mag[R_CAP_EXP] = react_mag;
  end

  for (genvar g = 0; g < 8; g++) begin : g_cell
    epa_accum_cell #(
      .RESIDUE_WIDTH(RESIDUE_WIDTH),
      .UNIT_WIDTH   (UNIT_WIDTH)
    ) u_cell (
      .clk         (clk),
      .rst         (rst),
      .ctrl        (cell_ctrl[g]),
      .mag         (cell_mag[g]),
      .pulse_energy(pulse_energy),
      .pulse       (cell_pulse[g])
    );
  end

  // Per-indicator quantum pulses; export apparent lights the apparent LED.
  logic p_act;
  logic p_app;
  logic p_react;

  assign p_act   = cell_pulse[R_ACT_IMP] || cell_pulse[R_ACT_EXP];
  assign p_app   = cell_pulse[R_APP_IMP] || cell_pulse[R_APP_EXP];
  assign p_react = cell_pulse[R_IND_IMP] || cell_pulse[R_IND_EXP] ||
                   cell_pulse[R_CAP_IMP] || cell_pulse[R_CAP_EXP];

  // Indicator timers.
  led_ctrl_t act_led_ctrl;
  led_ctrl_t app_led_ctrl;
  led_ctrl_t react_led_ctrl;
  logic      act_lit_next;
  logic      app_lit_next;
  logic      react_lit_next;

  assign act_led_ctrl   = '{step: step, pulse: p_act};
  assign app_led_ctrl   = '{step: step, pulse: p_app};
  assign react_led_ctrl = '{step: step, pulse: p_react};

  epa_led_timer u_act_led (
    .clk     (clk),
    .rst     (rst),
    .ctrl    (act_led_ctrl),
    .on_count(lit_ticks),
    .lit_next(act_lit_next)
  );

  epa_led_timer u_app_led (
    .clk     (clk),
    .rst     (rst),
    .ctrl    (app_led_ctrl),
    .on_count(lit_ticks),
    .lit_next(app_lit_next)
  );

  epa_led_timer u_react_led (
    .clk     (clk),
    .rst     (rst),
    .ctrl    (react_led_ctrl),
    .on_count(lit_ticks),
    .lit_next(react_lit_next)
  );

  // Result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (fire) begin
      result_valid <= 1'b1;
    end else if (!result_stall) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      active_led     <= act_lit_next;
      apparent_led   <= app_lit_next;
      reactive_led   <= react_lit_next;
      active_pulse   <= p_act;
      apparent_pulse <= p_app;
      reactive_pulse <= p_react;
      quadrant       <= in_hold ? QUAD_I : quad;
    end
  end

endmodule

### rtl/core/epa_checker.sv
// Port-level checks for energy_pulse_accumulator_unit, with its bind.
// Depends on energy_pulse_accumulator_unit_assert.svh.
`include "energy_pulse_accumulator_unit_assert.svh"

module epa_checker (
  input logic clk,
  input logic rst,
  input logic sample_stall,
  input logic result_valid,
  input logic result_stall,
  input logic active_led,
  input logic apparent_led,
  input logic reactive_led,
  input logic active_pulse,
  input logic apparent_pulse,
  input logic reactive_pulse
);

  logic pulse_lit_ok;

  assign pulse_lit_ok = (!active_pulse || active_led) &&
                        (!apparent_pulse || apparent_led) &&
                        (!reactive_pulse || reactive_led);

  // A completed quantum always leaves its indicator lit.
  `EPA_ASSERT(a_pulse_lights_led, clk, rst, result_valid |-> pulse_lit_ok)

  // With the result register empty the input side can never back up.
  `EPA_ASSERT(a_no_stall_when_empty, clk, rst, !result_valid |-> !sample_stall)

  // A stalled result transaction stays offered.
  `EPA_ASSERT(a_result_held, clk, rst, (result_valid && result_stall) |=> result_valid)

  // Reset empties the result side.
  `EPA_ASSERT_NR(a_reset_empty, clk, rst |=> !result_valid)

endmodule

bind energy_pulse_accumulator_unit epa_checker u_epa_checker (.*);
